>>> rtl/crp_pkg.sv
package crp_pkg;

  // operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_HEAD  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // result status codes
  localparam logic [3:0] ST_ACCEPTED = 4'd0;
  localparam logic [3:0] ST_DISABLED = 4'd1;
  localparam logic [3:0] ST_ZERO     = 4'd2;
  localparam logic [3:0] ST_NOSPACE  = 4'd3;
  localparam logic [3:0] ST_BUSY     = 4'd4;
  localparam logic [3:0] ST_STORED   = 4'd5;
  localparam logic [3:0] ST_DONE     = 4'd6;
  localparam logic [3:0] ST_IGNORED  = 4'd7;
  localparam logic [3:0] ST_CAUGHT   = 4'd8;
  localparam logic [3:0] ST_PENDING  = 4'd9;
  localparam logic [3:0] ST_READ     = 4'd10;

  localparam int unsigned QWORD_BYTES = 8;
  localparam int unsigned WORD_BYTES  = 4;
  localparam logic [31:0] NOOP_WORD   = 32'd0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  word_count;
    logic [31:0] data_word;
    logic [11:0] head_position;
    logic [9:0]  read_index;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [11:0] tail_offset;
    logic [11:0] free_bytes;
    logic [31:0] read_word;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pad;
    logic read_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic pad_needed;
    logic is_read;
  } dp_stat_t;

endpackage

>>> rtl/crp_ctrl.sv
module crp_ctrl
  import crp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t dp_stat,
  output ctrl_t    ctrl,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PAD  = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (dp_stat.is_read) begin
            state_next = S_READ;
          end else if (dp_stat.pad_needed) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD:   state_next = S_IDLE;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy          = (state != S_IDLE);
  assign ctrl.accept   = (state == S_IDLE) && start;
  assign ctrl.pad      = (state == S_PAD);
  assign ctrl.read_out = (state == S_READ);

endmodule

>>> rtl/crp_datapath.sv
module crp_datapath
  import crp_pkg::*;
#(
  parameter int unsigned RING_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_item_t cmd,
  input  ctrl_t     ctrl,
  input  logic      cfg_write,
  input  logic      cfg_data,
  output dp_stat_t  dp_stat,
  output logic      strobe,
  output result_t   result
);

  localparam int unsigned TW = $clog2(RING_BYTES);
  localparam int unsigned WW = TW - 2;
  localparam int unsigned RW = RING_BYTES / 4;
  localparam int unsigned CW = (TW + 1 > 13) ? TW + 1 : 13;

  logic [31:0]   ring_store [RW];
  logic [31:0]   rdata;
  logic [TW-1:0] write_tail;
  logic [TW-1:0] last_head;
  logic [9:0]    words_remaining;
  logic          batch_open;
  logic          enable;

  logic [TW-1:0] used;
  logic [TW:0]   avail;
  logic [TW:0]   fb;
  logic [CW-1:0] need;
  logic [TW-1:0] head_mod;
  logic [TW-1:0] tail_adv;
  logic          data_store;
  logic          last_word;
  logic          mem_we;
  logic [31:0]   mem_wdata;
  logic [3:0]    begin_status;
  result_t       result_next;

  assign used     = write_tail - last_head;
  assign avail    = (TW + 1)'(RING_BYTES) - {1'b0, used};
  assign fb       = (avail > (TW + 1)'(QWORD_BYTES)) ? avail - (TW + 1)'(QWORD_BYTES)
                                                    : '0;
  assign need     = CW'({cmd.word_count, 2'b00}) + CW'(QWORD_BYTES);
  assign head_mod = TW'(cmd.head_position);
  assign tail_adv = write_tail + TW'(WORD_BYTES);

  assign data_store = (cmd.operation == OP_DATA) && batch_open;
  assign last_word  = (words_remaining == 10'd1);

  // a batch ending off qword alignment takes one pad word in the next cycle
  assign dp_stat.pad_needed = data_store && last_word && !write_tail[2];
  assign dp_stat.is_read    = (cmd.operation == OP_READ);

  always_comb begin
    priority if (batch_open) begin
      begin_status = ST_BUSY;
    end else if (!enable) begin
      begin_status = ST_DISABLED;
    end else if (cmd.word_count == 10'd0) begin
      begin_status = ST_ZERO;
    end else if (CW'(fb) < need) begin
      begin_status = ST_NOSPACE;
    end else begin
      begin_status = ST_ACCEPTED;
    end
  end

  assign mem_we    = (ctrl.accept && data_store) || ctrl.pad;
  assign mem_wdata = ctrl.pad ? NOOP_WORD : cmd.data_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_store[write_tail[TW-1:2]] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && (cmd.operation == OP_READ)) begin
      rdata <= ring_store[WW'(cmd.read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_write) begin
      enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_tail      <= '0;
      last_head       <= '0;
      words_remaining <= '0;
      batch_open      <= 1'b0;
    end else if (ctrl.pad) begin
      write_tail <= tail_adv;
    end else if (ctrl.accept) begin
      unique case (cmd.operation)
        OP_BEGIN: begin
          if (begin_status == ST_ACCEPTED) begin
            batch_open      <= 1'b1;
            words_remaining <= cmd.word_count;
          end
        end
        OP_DATA: begin
          if (batch_open) begin
            write_tail      <= tail_adv;
            words_remaining <= words_remaining - 10'd1;
            if (last_word) begin
              batch_open <= 1'b0;
            end
          end
        end
        OP_HEAD: last_head <= head_mod;
        OP_READ: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.pad || ctrl.read_out
                || (ctrl.accept && !dp_stat.pad_needed && !dp_stat.is_read);
    end
  end

  always_comb begin
    result_next             = '0;
    result_next.tail_offset = 12'(write_tail);
    if (ctrl.pad) begin
      result_next.status      = ST_DONE;
      result_next.tail_offset = 12'(tail_adv);
    end else if (ctrl.read_out) begin
      result_next.status    = ST_READ;
      result_next.read_word = rdata;
    end else begin
      unique case (cmd.operation)
        OP_BEGIN: begin
          result_next.status     = begin_status;
          result_next.free_bytes = 12'(fb);
        end
        OP_DATA: begin
          if (!batch_open) begin
            result_next.status = ST_IGNORED;
          end else begin
            result_next.status      = last_word ? ST_DONE : ST_STORED;
            result_next.tail_offset = 12'(tail_adv);
          end
        end
        OP_HEAD: result_next.status = (head_mod == write_tail) ? ST_CAUGHT : ST_PENDING;
        OP_READ: result_next.status = ST_READ;
        default: result_next.status = ST_READ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> rtl/command_ring_producer_top.sv
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      cmd (cmd_item_t)
// result    out        strobe, one cycle         result (result_t)
// config    in         cfg_valid and cfg_ready   cfg_data (enable)
//
// Begin, head report and most data words: result in the cycle after acceptance;
// a new request may be taken in every cycle.
// A data word closing a batch off qword alignment: the pad write then takes the single
// ring write port in the S_PAD state, with busy high while the pad is written.
// Read entry: the result follows the registered ring read and the S_READ state, busy for one cycle.
// Synchronous reset leaves the ring contents; the receiver cannot stall.
module command_ring_producer_top
  import crp_pkg::*;
#(
  parameter int unsigned RING_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cmd_item_t cmd,
  output logic      strobe,
  output result_t   result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  ctrl_t    ctrl;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  crp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  crp_datapath #(
    .RING_BYTES (RING_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .dp_stat   (dp_stat),
    .strobe    (strobe),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_busy_no_strobe: assert property (@(posedge clk) disable iff (rst)
    busy |-> !strobe)
    else $error("result strobe during a busy cycle");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.operation == OP_READ)) |=> busy ##1 strobe)
    else $error("read request did not return after two cycles");

  a_read_after_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.status == ST_READ)) |-> $past(busy))
    else $error("read result without the read cycle");

  a_done_aligned: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.status == ST_DONE)) |-> (result.tail_offset[2:0] == 3'd0))
    else $error("published tail not qword aligned");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import crp_pkg::*;

  localparam int unsigned RING_SIZE    = 4096;
  localparam int unsigned RING_ENTRIES = RING_SIZE / WORD_BYTES;
  localparam int unsigned RANDOM_ITEMS = 1550;

  typedef struct {
    bit        is_cfg;
    bit        cfg_val;
    cmd_item_t item;
    bit        typed;
    result_t   want;
  } step_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  cmd_item_t cmd;
  logic      strobe;
  result_t   result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  // shadow of the ring and of the producer pointers
  logic [31:0]  ring_words [RING_ENTRIES];
  bit           ring_filled [RING_ENTRIES];
  int unsigned  filled_list[$];
  logic [11:0]  tail_q;
  logic [11:0]  head_q;
  logic [9:0]   left_q;
  bit           open_q;
  bit           enable_q;

  result_t      pending_results[$];
  step_t        plan[$];
  int           mismatches = 0;
  int unsigned  issued = 0;
  bit           quiet = 0;

  command_ring_producer_top #(
    .RING_BYTES(RING_SIZE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .strobe   (strobe),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned ring_free();
    logic [11:0] used;
    int unsigned avail;
    used  = tail_q - head_q;
    avail = RING_SIZE - used;
    return (avail > QWORD_BYTES) ? avail - QWORD_BYTES : 0;
  endfunction

  function automatic void put_word(logic [31:0] w);
    if (!ring_filled[tail_q[11:2]]) begin
      ring_filled[tail_q[11:2]] = 1'b1;
      filled_list.push_back(tail_q[11:2]);
    end
    ring_words[tail_q[11:2]] = w;
    tail_q = tail_q + 12'(WORD_BYTES);
  endfunction

  function automatic result_t ring_predict(cmd_item_t c);
    result_t     r;
    int unsigned need;
    r = '0;
    case (c.operation)
      OP_BEGIN: begin
        r.free_bytes = 12'(ring_free());
        need = c.word_count * WORD_BYTES + QWORD_BYTES;
        if (open_q) r.status = ST_BUSY;
        else if (!enable_q) r.status = ST_DISABLED;
        else if (c.word_count == 0) r.status = ST_ZERO;
        else if (ring_free() < need) r.status = ST_NOSPACE;
        else begin
          open_q = 1'b1;
          left_q = c.word_count;
          r.status = ST_ACCEPTED;
        end
      end
      OP_DATA: begin
        if (!open_q) begin
          r.status = ST_IGNORED;
        end else begin
          put_word(c.data_word);
          left_q = left_q - 10'd1;
          if (left_q == 0) begin
            // pad the tail out to the next qword
            while (tail_q[2:0] != 0) put_word(NOOP_WORD);
            open_q = 1'b0;
            r.status = ST_DONE;
          end else begin
            r.status = ST_STORED;
          end
        end
      end
      OP_HEAD: begin
        head_q = c.head_position;
        r.status = (head_q == tail_q) ? ST_CAUGHT : ST_PENDING;
      end
      default: begin
        r.read_word = ring_words[c.read_index];
        r.status = ST_READ;
      end
    endcase
    r.tail_offset = tail_q;
    return r;
  endfunction

  function automatic step_t cmd_row(logic [1:0] op, logic [9:0] cnt, logic [31:0] w,
                                    logic [11:0] hd, logic [9:0] ix, bit typed = 0,
                                    logic [3:0] st = ST_ACCEPTED, logic [11:0] tl = '0,
                                    logic [11:0] fb = '0);
    step_t s;
    s.is_cfg  = 1'b0;
    s.cfg_val = 1'b0;
    s.item    = {op, cnt, w, hd, ix};
    s.typed   = typed;
    s.want    = {st, tl, fb, 32'd0};
    return s;
  endfunction

  function automatic step_t cfg_row(bit v);
    step_t s;
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    s.item    = '0;
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_item_t rand_item(logic [1:0] op);
    cmd_item_t c;
    c.operation     = op;
    c.word_count    = 10'($urandom);
    c.data_word     = $urandom;
    c.head_position = 12'($urandom);
    c.read_index    = 10'($urandom);
    return c;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", result.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          mismatches++;
        end
        if (result.tail_offset !== want.tail_offset) begin
          $error("tail_offset: expected %0d, got %0d", want.tail_offset, result.tail_offset);
          mismatches++;
        end
        if (result.free_bytes !== want.free_bytes) begin
          $error("free_bytes: expected %0d, got %0d", want.free_bytes, result.free_bytes);
          mismatches++;
        end
        if (result.read_word !== want.read_word) begin
          $error("read_word: expected %h, got %h", want.read_word, result.read_word);
          mismatches++;
        end
      end
    end
  end

  task automatic issue(cmd_item_t c, bit typed = 0, result_t want = '0);
    result_t predicted;
    int      gap;
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = ring_predict(c);
    pending_results.push_back(typed ? want : predicted);
    if (predicted.status != ST_IGNORED) issued++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_enable(bit v);
    if (start) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    enable_q = v;
  endtask

  task automatic issue_head(bit catch_up);
    cmd_item_t c;
    int        r;
    c = rand_item(OP_HEAD);
    r = $urandom_range(0, 99);
    if (catch_up || r < 60) c.head_position = tail_q;
    else if (r < 85) c.head_position = head_q + 12'($urandom_range(0, 12'(tail_q - head_q)));
    issue(c);
  endtask

  task automatic issue_read();
    cmd_item_t c;
    // only entries already written may be read back
    if (filled_list.size() == 0) begin
      issue_head(1'b0);
    end else begin
      c = rand_item(OP_READ);
      c.read_index = 10'(filled_list[$urandom_range(0, filled_list.size() - 1)]);
      issue(c);
    end
  endtask

  task automatic issue_data();
    cmd_item_t c;
    int        r;
    c = rand_item(OP_DATA);
    r = $urandom_range(0, 99);
    if (r < 5) c.data_word = '1;
    else if (r < 10) c.data_word = '0;
    issue(c);
  endtask

  task automatic run_batch();
    cmd_item_t c;
    int        r;
    if (!open_q) begin
      c = rand_item(OP_BEGIN);
      r = $urandom_range(0, 99);
      if (r < 90) c.word_count = 10'($urandom_range(1, 12));
      else if (r < 97) c.word_count = 10'($urandom_range(13, 200));
      else c.word_count = 10'($urandom_range(200, 1020));
      // let the engine catch up first so that long batches fit
      if (c.word_count > 12 && $urandom_range(0, 1) == 1) issue_head(1'b1);
      issue(c);
    end
    while (open_q) begin
      r = $urandom_range(0, 99);
      if (r < 85) issue_data();
      else if (r < 91) issue_head(1'b0);
      else if (r < 96) issue_read();
      else issue(rand_item(OP_BEGIN));
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned quota;
    int          r;
    cmd_item_t   c;
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    tail_q    = '0;
    head_q    = '0;
    left_q    = '0;
    open_q    = 1'b0;
    enable_q  = 1'b0;

    plan.push_back(cmd_row(OP_HEAD, 0, 0, 0, 0, 1, ST_CAUGHT, 0, 0));
    plan.push_back(cmd_row(OP_BEGIN, 1, 0, 0, 0, 1, ST_DISABLED, 0, 4088));
    plan.push_back(cmd_row(OP_DATA, 0, 32'hFFFF_FFFF, 0, 0, 1, ST_IGNORED, 0, 0));
    plan.push_back(cfg_row(1'b1));
    plan.push_back(cmd_row(OP_BEGIN, 0, 0, 0, 0, 1, ST_ZERO, 0, 4088));
    plan.push_back(cmd_row(OP_BEGIN, 10'd1023, 0, 0, 0, 1, ST_NOSPACE, 0, 4088));
    plan.push_back(cmd_row(OP_HEAD, 0, 0, 12'd4095, 0, 1, ST_PENDING, 0, 0));
    plan.push_back(cmd_row(OP_BEGIN, 10'd1020, 0, 0, 0));
    plan.push_back(cmd_row(OP_HEAD, 0, 0, 0, 0, 1, ST_CAUGHT, 0, 0));
    plan.push_back(cmd_row(OP_BEGIN, 3, 0, 0, 0, 1, ST_ACCEPTED, 0, 4088));
    plan.push_back(cmd_row(OP_BEGIN, 5, 0, 0, 0, 1, ST_BUSY, 0, 4088));
    plan.push_back(cmd_row(OP_DATA, 0, 32'hFFFF_FFFF, 0, 0));
    plan.push_back(cmd_row(OP_HEAD, 0, 0, 0, 0));
    plan.push_back(cmd_row(OP_DATA, 0, 32'h0000_0000, 0, 0));
    plan.push_back(cmd_row(OP_DATA, 0, 32'hA5A5_5A5A, 0, 0));
    plan.push_back(cmd_row(OP_READ, 0, 0, 0, 2));
    plan.push_back(cmd_row(OP_READ, 0, 0, 0, 3));
    plan.push_back(cmd_row(OP_READ, 0, 0, 0, 0));
    plan.push_back(cmd_row(OP_HEAD, 0, 0, 12'd16, 0));
    plan.push_back(cmd_row(OP_BEGIN, 1, 0, 0, 0));
    // drop enable with a batch open: the batch must still complete
    plan.push_back(cfg_row(1'b0));
    plan.push_back(cmd_row(OP_DATA, 0, 32'h1234_5678, 0, 0));
    plan.push_back(cmd_row(OP_BEGIN, 2, 0, 0, 0));
    plan.push_back(cmd_row(OP_DATA, 0, 32'h8765_4321, 0, 0));
    plan.push_back(cfg_row(1'b1));
    plan.push_back(cmd_row(OP_BEGIN, 10'd1020, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_enable(plan[i].cfg_val);
      else issue(plan[i].item, plan[i].typed, plan[i].want);
    end

    target = issued + RANDOM_ITEMS;
    for (int p = 0; issued < target; p++) begin
      quiet = (p % 3 == 2);
      set_enable(p % 4 != 1);
      quota = issued + ((p % 4 != 1) ? 240 : 40);
      while (issued < quota) begin
        r = $urandom_range(0, 99);
        if (r < 70) run_batch();
        else if (r < 82) issue_head(1'b0);
        else if (r < 92) issue_read();
        else begin
          c = rand_item(2'($urandom));
          if (c.operation == OP_READ) issue_read();
          else issue(c);
        end
      end
    end

    if (start) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
